// File: rtl/mmcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared widths, codes and control structs for the min-max contrast stretch.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    localparam int PIX_W     = 16;              // pixel width
    localparam int VAL_W     = 16;              // out_max and mapped value width
    localparam int PROD_W    = PIX_W + VAL_W;   // product out_max * (p - min)
    localparam int DIV_STEPS = VAL_W;           // quotient bits, one per cycle
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [VAL_W-1:0] OUT_MAX_RESET = VAL_W'(255);
    localparam logic [PIX_W-1:0] PIX_ALL_ONES  = '1;

    // transaction kinds
    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_MAP     = 1'b1;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage : mmcs_pkg
`default_nettype wire

// File: rtl/minmax_contrast_stretch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// minmax_contrast_stretch
// Two-pass contrast stretch: measure transactions track the image min/max,
// map transactions scale a pixel to 0..out_max.
// ----------------------------------------------------------------------------
//   channel  prefix  direction  payload
//   input    s_      in         kind, restart, pixel
//   result   m_      out        mapped_value (map transactions only)
//   config   cfg_    in         out_max
//
// a measure transaction updates the statistics in its accept cycle; a map
// that clips to 0 or out_max goes through the hold state into the output reg,
// a map that scales passes the accept cycle, a multiply state, the bit-serial
// divider, the collection of the quotient and the hand-off into the output reg.
// one transaction is in work at a time; the output register lets the next
// transaction in while a result still waits on m_ready.
// synchronous active-low reset clears the statistics and sets out_max to 255.
// ----------------------------------------------------------------------------
module minmax_contrast_stretch
    import mmcs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_kind,
    input  wire logic             s_restart,
    input  wire logic [PIX_W-1:0] s_pixel,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [VAL_W-1:0]      m_mapped_value,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [VAL_W-1:0] cfg_out_max
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t           state_reg,   state_next;
    logic [VAL_W-1:0] out_max_reg, out_max_next;
    logic [PIX_W-1:0] low_reg,     low_next;
    logic [PIX_W-1:0] high_reg,    high_next;
    logic             have_reg,    have_next;
    logic [PIX_W-1:0] diff_reg,    diff_next;
    logic [PIX_W-1:0] den_reg,     den_next;
    logic [VAL_W-1:0] res_reg,     res_next;
    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] m_value_reg, m_value_next;

    logic             s_accept;
    logic [PIX_W-1:0] eff_low;
    logic [PIX_W-1:0] eff_high;
    logic             out_free;
    logic [PROD_W-1:0] product;

    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [VAL_W-1:0] div_quotient;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // restart clears the statistics ahead of this measure
    assign eff_low  = s_restart ? PIX_ALL_ONES : low_reg;
    assign eff_high = s_restart ? '0 : high_reg;

    assign product = PROD_W'(out_max_reg) * PROD_W'(diff_reg);

    always_comb begin
        state_next    = state_reg;
        out_max_next  = out_max_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        have_next     = have_reg;
        diff_next     = diff_reg;
        den_next      = den_reg;
        res_next      = res_reg;
        div_ctrl      = '0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;

        if (cfg_valid && cfg_ready) begin
            out_max_next = cfg_out_max;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_kind == KIND_MEASURE) begin
                        low_next  = (s_pixel < eff_low)  ? s_pixel : eff_low;
                        high_next = (s_pixel > eff_high) ? s_pixel : eff_high;
                        have_next = 1'b1;
                    end else if (!have_reg || s_pixel < low_reg) begin
                        res_next   = '0;
                        state_next = ST_HOLD;
                    end else if (s_pixel >= high_reg) begin
                        res_next   = out_max_reg;
                        state_next = ST_HOLD;
                    end else begin
                        diff_next  = s_pixel - low_reg;
                        den_next   = high_reg - low_reg;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // product goes straight into the divider's registers
                div_ctrl.start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    res_next   = div_quotient;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_max_reg <= OUT_MAX_RESET;
            low_reg     <= PIX_ALL_ONES;
            high_reg    <= '0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_max_reg <= out_max_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
        end
        diff_reg    <= diff_next;
        den_reg     <= den_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
    end

    mmcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (product),
        .divisor  (den_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign m_valid        = m_valid_reg;
    assign m_mapped_value = m_value_reg;

    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("input ready while divider still running");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_stats_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        have_reg |-> (low_reg <= high_reg))
        else $error("measured minimum above maximum");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (den_reg != '0 && diff_reg < den_reg))
        else $error("scaling with a bad span");

endmodule : minmax_contrast_stretch
`default_nettype wire

// File: rtl/mmcs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller
// guarantees dividend < divisor * 2**VAL_W, so the quotient fits VAL_W bits.
// ----------------------------------------------------------------------------
module mmcs_div
    import mmcs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_ctrl_t         ctrl,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [PIX_W-1:0]  divisor,
    output div_stat_t              stat,
    output logic [VAL_W-1:0]       quotient
);

    logic             busy_reg,    busy_next;
    logic             done_reg,    done_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [PIX_W-1:0] rem_reg,     rem_next;
    logic [VAL_W-1:0] quo_reg,     quo_next;
    logic [PIX_W-1:0] divisor_reg, divisor_next;

    logic [PIX_W:0]   shifted;
    logic [PIX_W:0]   trial;
    logic             fits;

    // bring in the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[VAL_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign fits    = (shifted >= {1'b0, divisor_reg});

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (ctrl.start) begin
            busy_next    = 1'b1;
            count_next   = CNT_W'(DIV_STEPS - 1);
            rem_next     = dividend[PROD_W-1:VAL_W];
            quo_next     = dividend[VAL_W-1:0];
            divisor_next = divisor;
        end else if (busy_reg) begin
            rem_next   = fits ? trial[PIX_W-1:0] : shifted[PIX_W-1:0];
            quo_next   = {quo_reg[VAL_W-2:0], fits};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    // partial remainder always stays below the divisor
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    a_no_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !ctrl.start)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule : mmcs_div
`default_nettype wire

// File: dv/minmax_contrast_stretch_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_contrast_stretch_tb
// Drives measure and map transactions into the contrast stretch block under
// several out_max levels. A scoreboard keeps its own copy of the image min/max
// statistics, predicts each mapped pixel and checks results in order. Both
// channels idle at random, and the result side holds off once for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
module minmax_contrast_stretch_tb
    import mmcs_pkg::*;
();

    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all
    localparam int SETTLE_WAIT  = 40;    // extra wait after the last expected result
    localparam int ITEMS_PHASE  = 85;
    localparam int HOLD_CYCLES  = 300;

    class stretch_checker;
        logic [VAL_W-1:0] out_max;
        logic [PIX_W-1:0] low_seen;
        logic [PIX_W-1:0] high_seen;
        logic             have_sample;
        logic [VAL_W-1:0] pending_levels[$];
        int               errors;

        function new();
            out_max = OUT_MAX_RESET;
            clear_stats();
            errors  = 0;
        endfunction

        function void clear_stats();
            low_seen    = PIX_ALL_ONES;
            high_seen   = '0;
            have_sample = 1'b0;
        endfunction

        function void set_out_max(logic [VAL_W-1:0] level);
            out_max = level;
        endfunction

        function logic [VAL_W-1:0] stretch_pixel(logic [PIX_W-1:0] p);
            logic [PROD_W-1:0] scaled;
            if (!have_sample || p < low_seen) return '0;
            if (p >= high_seen) return out_max;
            // high_seen > p >= low_seen here, so the divisor is nonzero
            scaled = PROD_W'(out_max) * PROD_W'(p - low_seen);
            return VAL_W'(scaled / PROD_W'(high_seen - low_seen));
        endfunction

        function void note_input(logic kind, logic restart, logic [PIX_W-1:0] pixel);
            if (kind == KIND_MEASURE) begin
                if (restart) clear_stats();
                if (pixel < low_seen) low_seen = pixel;
                if (pixel > high_seen) high_seen = pixel;
                have_sample = 1'b1;
            end else begin
                // restart on a map transaction has no effect
                pending_levels.push_back(stretch_pixel(pixel));
            end
        endfunction

        function void check_result(logic [VAL_W-1:0] actual);
            logic [VAL_W-1:0] wanted;
            if (pending_levels.size() == 0) begin
                $error("mapped_value: no result expected, actual %0d", actual);
                errors++;
                return;
            end
            wanted = pending_levels.pop_front();
            if (actual !== wanted) begin
                $error("mapped_value mismatch: expected %0d, actual %0d", wanted, actual);
                errors++;
            end
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_kind;
    logic             s_restart;
    logic [PIX_W-1:0] s_pixel;
    logic             m_valid;
    logic             m_ready;
    logic [VAL_W-1:0] m_mapped_value;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [VAL_W-1:0] cfg_out_max;

    stretch_checker sb = new();
    int sent_count   = 0;
    int result_count = 0;

    minmax_contrast_stretch dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_restart      (s_restart),
        .s_pixel        (s_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mapped_value (m_mapped_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_out_max    (cfg_out_max)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // drive tasks, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(logic kind, logic restart, logic [PIX_W-1:0] pixel);
        // no idling across a long window of the run
        while (!(sent_count >= 300 && sent_count < 420) && $urandom_range(0, 99) < 7) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_kind    = kind;
        s_restart = restart;
        s_pixel   = pixel;
        s_valid   = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(kind, restart, pixel);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic write_out_max(logic [VAL_W-1:0] level);
        cfg_out_max = level;
        cfg_valid   = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_out_max(level);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        // measure transactions have no result and are finished once accepted
        repeat (SETTLE_WAIT) @(negedge aclk);
    endtask

    // one image: a measure pass with pixels in [lo, hi], then a map pass
    // with pixels a little outside that range too
    task automatic send_image(output int count);
        int lo;
        int hi;
        int span;
        int n_meas;
        int n_map;
        int i;
        int p;
        lo = $urandom_range(0, 65535);
        case ($urandom_range(0, 2))
            0: span = $urandom_range(0, 15);
            1: span = $urandom_range(0, 4095);
            default: span = $urandom_range(0, 65535);
        endcase
        hi = (lo + span > 65535) ? 65535 : lo + span;
        n_meas = $urandom_range(1, 6);
        n_map  = $urandom_range(1, 10);
        for (i = 0; i < n_meas; i++) begin
            p = (i == 0) ? lo : (i == 1) ? hi : $urandom_range(lo, hi);
            // now and then the statistics carry over from the last image
            send_item(KIND_MEASURE, (i == 0) && ($urandom_range(0, 9) != 0), PIX_W'(p));
        end
        for (i = 0; i < n_map; i++) begin
            p = $urandom_range((lo >= 8) ? lo - 8 : 0, (hi <= 65527) ? hi + 8 : 65535);
            send_item(KIND_MAP, 1'($urandom_range(0, 1)), PIX_W'(p));
        end
        count = n_meas + n_map;
    endtask

    task automatic run_random(int n_items);
        int done_items;
        int image_items;
        int i;
        done_items = 0;
        while (done_items < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                send_image(image_items);
                done_items += image_items;
            end else begin
                for (i = $urandom_range(1, 3); i > 0; i--) begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              PIX_W'($urandom_range(0, 65535)));
                    done_items++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls plus one long hold-off while input continues
    // ------------------------------------------------------------------------
    initial begin
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_mapped_value);
                result_count++;
            end
            @(negedge aclk);
            if (!held && result_count >= 60) begin
                held    = 1'b1;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (result_count >= 150 && result_count < 230)
                m_ready = 1'b1;
            else
                m_ready = ($urandom_range(0, 99) >= 7);
        end
    end

    // watchdog: cycles in a row with no transaction on any channel
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("** minmax_contrast_stretch: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [VAL_W-1:0] levels[6];
        int k;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_kind      = KIND_MEASURE;
        s_restart   = 1'b0;
        s_pixel     = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_out_max = '0;
        levels = '{16'hFFFF, 16'd1, 16'd0, 16'd0, 16'h8000, 16'd255};
        levels[3] = VAL_W'($urandom_range(2, 65534));

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed part, out_max still at its reset level
        send_item(KIND_MAP,     1'b0, 16'd100);     // nothing measured yet
        send_item(KIND_MAP,     1'b1, 16'd0);       // restart on a map, nothing measured
        send_item(KIND_MEASURE, 1'b1, 16'd500);
        send_item(KIND_MAP,     1'b0, 16'd500);     // min equals max
        send_item(KIND_MAP,     1'b0, 16'd499);
        send_item(KIND_MAP,     1'b0, 16'hFFFF);
        send_item(KIND_MEASURE, 1'b0, 16'd0);
        send_item(KIND_MEASURE, 1'b0, 16'hFFFF);
        send_item(KIND_MAP,     1'b0, 16'd0);
        send_item(KIND_MAP,     1'b0, 16'hFFFE);
        send_item(KIND_MAP,     1'b0, 16'h8000);
        send_item(KIND_MAP,     1'b0, 16'd1);
        send_item(KIND_MAP,     1'b1, 16'd12345);   // restart ignored on a map
        send_item(KIND_MEASURE, 1'b1, 16'd1000);
        send_item(KIND_MEASURE, 1'b0, 16'd3000);
        send_item(KIND_MAP,     1'b0, 16'd999);
        send_item(KIND_MAP,     1'b0, 16'd1000);
        send_item(KIND_MAP,     1'b0, 16'd2999);
        send_item(KIND_MAP,     1'b0, 16'd3000);
        send_item(KIND_MEASURE, 1'b0, 16'hFFFF);
        send_item(KIND_MEASURE, 1'b1, 16'hFFFF);    // min and max both at full scale
        send_item(KIND_MAP,     1'b0, 16'hFFFF);
        send_item(KIND_MAP,     1'b0, 16'd0);
        run_random(ITEMS_PHASE);

        for (k = 0; k < 6; k++) begin
            wait_idle();
            write_out_max(levels[k]);
            run_random(ITEMS_PHASE);
        end

        wait_idle();
        if (sb.pending() != 0) begin
            $error("mapped_value: %0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("** minmax_contrast_stretch: PASSED **");
        else
            $display("** minmax_contrast_stretch: FAILED **");
        $finish;
    end

endmodule
